>>> src/sva_pkg.sv
package sva_pkg;

  // Block dimensions
  localparam int NUM_VOICES  = 16;
  localparam int MAX_SOUNDS  = 256;
  localparam int START_VOICE = 0;

  localparam int VOICE_W   = $clog2(NUM_VOICES);
  localparam int SAMPLE_AW = $clog2(MAX_SOUNDS);

  // Field widths
  localparam int MODE_W     = 2;
  localparam int SAMPLE_W   = 8;
  localparam int PRIO_W     = 8;
  localparam int PITCH_W    = 16;
  localparam int VIDX_W     = 4;
  localparam int FLAGS_W    = 16;
  localparam int STATUS_W   = 3;
  localparam int NSOUNDS_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PLAY        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP_SAMPLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP_VOICE  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_PLAYED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STOPPED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTHING  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SOUNDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PRIO   = 2'd1;

  localparam logic [NSOUNDS_W-1:0] NUM_SOUNDS_RST = 9'd256;
  localparam logic [PRIO_W-1:0]    LOW_PRIO_RST   = 8'd1;

  // First voice scanned after reset, and the highest voice number
  localparam logic [VOICE_W-1:0] SCAN_START_RST = VOICE_W'((START_VOICE + 1) % NUM_VOICES);
  localparam logic [VOICE_W-1:0] LAST_VOICE     = VOICE_W'(NUM_VOICES - 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [PRIO_W-1:0]   prio;
    logic                loops;
  } voice_rec_t;

  typedef struct packed {
    logic               valid;
    logic [VOICE_W-1:0] voice;
  } map_entry_t;

endpackage

>>> src/sva_ifs.sv
interface sva_req_if;
  logic                           valid;
  logic                           ready;
  logic [sva_pkg::MODE_W-1:0]     mode;
  logic [sva_pkg::SAMPLE_W-1:0]   sample_number;
  logic [sva_pkg::PRIO_W-1:0]     priority_req;
  logic                           looping;
  logic [sva_pkg::PITCH_W-1:0]    pitch;
  logic [sva_pkg::VIDX_W-1:0]     voice_index;
  logic [sva_pkg::FLAGS_W-1:0]    voice_end_flags;

  modport source (output valid, mode, sample_number, priority_req, looping, pitch,
                  voice_index, voice_end_flags, input ready);
  modport sink   (input valid, mode, sample_number, priority_req, looping, pitch,
                  voice_index, voice_end_flags, output ready);
endinterface

interface sva_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [sva_pkg::STATUS_W-1:0]   status;
  logic [sva_pkg::VIDX_W-1:0]     voice;
  logic [sva_pkg::SAMPLE_W-1:0]   played_sample;
  logic [sva_pkg::PITCH_W-1:0]    played_pitch;

  modport source (output valid, status, voice, played_sample, played_pitch, input ready);
  modport sink   (input valid, status, voice, played_sample, played_pitch, output ready);
endinterface

interface sva_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sva_pkg::CFG_IDX_W-1:0]   index;
  logic [sva_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/sva_voice_cell.sv
module sva_voice_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  sva_pkg::voice_rec_t rec_i,
  output sva_pkg::voice_rec_t rec_o
);
  import sva_pkg::*;

  voice_rec_t rec_q, rec_d;

  // Take the neighbor's record on a shift, hold otherwise
  always_comb begin
    rec_d = shift_i ? rec_i : rec_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

>>> src/sva_map.sv
module sva_map (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [sva_pkg::SAMPLE_AW-1:0]    rd_addr_i,
  output sva_pkg::map_entry_t              rd_o,
  input  logic                             wr_en_i,
  input  logic                             wr_set_i,
  input  logic [sva_pkg::SAMPLE_AW-1:0]    wr_addr_i,
  input  logic [sva_pkg::VOICE_W-1:0]      wr_voice_i
);
  import sva_pkg::*;

  logic [VOICE_W-1:0]    mem_q [MAX_SOUNDS];
  logic [MAX_SOUNDS-1:0] valid_q;
  logic [VOICE_W-1:0]    rd_voice_q;
  logic                  rd_valid_q;

  // Voice numbers: plain memory, meaningful only where the valid bit is set
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_set_i) begin
      mem_q[wr_addr_i] <= wr_voice_i;
    end
    if (rd_en_i) begin
      rd_voice_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= wr_set_i;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_o = '{valid: rd_valid_q, voice: rd_voice_q};

endmodule

>>> src/sound_voice_allocator_top.sv
// Sound voice allocator.
//
// req_i carries one word per request: play a sample, stop by sample number,
// or stop by voice. rsp_o returns exactly one word per request: status, the
// voice started or keyed off, and the sample and pitch to program on a play.
// cfg_i writes num_sounds (index 0) and low_priority_level (index 1); it is
// always ready and must only be used while no request is in flight.
//
// The voice records live in a ring of NUM_VOICES cells that rotates by one
// cell per cycle during a scan or write-back. A play or stop by sample takes
// one full rotation to scan every voice and a second rotation to write the
// chosen voice back. A rejected play or a stop by sample that finds nothing
// skips the write-back; a stop by voice skips the scan, and a bad sample or
// an unknown mode skips both. One request is in flight at a time.
// The sample-to-voice map is a memory with one registered read port and
// per-entry valid bits.
// Reset clears all voices and all map valid bits and returns the config registers to their reset values.
// A stalled rsp_o holds its word; the next request is still accepted and runs
// to completion, then waits until the output register frees.
module sound_voice_allocator_top (
  input logic        clk_i,
  input logic        rst_ni,
  sva_req_if.sink    req_i,
  sva_rsp_if.source  rsp_o,
  sva_cfg_if.sink    cfg_i
);
  import sva_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WRITE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  // Config registers
  logic [NSOUNDS_W-1:0] num_sounds_q, num_sounds_d;
  logic [PRIO_W-1:0]    low_prio_q, low_prio_d;

  // Latched request
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic [PRIO_W-1:0]   prio_q, prio_d;
  logic                loop_q, loop_d;
  logic [PITCH_W-1:0]  pitch_q, pitch_d;
  logic [FLAGS_W-1:0]  flags_q, flags_d;

  // Scan bookkeeping
  logic [VOICE_W-1:0] cnt_q, cnt_d;
  logic [VOICE_W-1:0] start_q, start_d;
  logic               hit_q, hit_d;
  logic               free_found_q, free_found_d;
  logic [VOICE_W-1:0] free_rel_q, free_rel_d;
  logic [VOICE_W-1:0] free_v_q, free_v_d;
  logic               prio_found_q, prio_found_d;
  logic [VOICE_W-1:0] prio_rel_q, prio_rel_d;
  logic [VOICE_W-1:0] prio_v_q, prio_v_d;
  logic [VOICE_W-1:0] target_q, target_d;
  logic               clear_q, clear_d;

  // Pending result and output register
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [VIDX_W-1:0]   res_voice_q, res_voice_d;
  logic [SAMPLE_W-1:0] res_sample_q, res_sample_d;
  logic [PITCH_W-1:0]  res_pitch_q, res_pitch_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [VIDX_W-1:0]   out_voice_q, out_voice_d;
  logic [SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic [PITCH_W-1:0]  out_pitch_q, out_pitch_d;

  // Voice ring
  voice_rec_t cell_rec [NUM_VOICES];
  voice_rec_t head;
  voice_rec_t tail_in;
  logic       shift;

  // Map ports
  logic                 map_rd_en;
  map_entry_t           map_rd;
  logic                 map_wr_en;
  logic                 map_wr_set;
  logic [VOICE_W-1:0]   map_wr_voice;

  // Scan helpers
  logic                 req_acc;
  logic                 sample_ok;
  logic [FLAGS_W-1:0]   end_sh;
  logic                 ended;
  logic                 free_cand;
  logic                 prio_cand;
  logic [VOICE_W:0]     rel_wide;
  logic [VOICE_W-1:0]   rel;
  logic [VOICE_W-1:0]   chosen_v;
  logic                 chosen_ok;

  assign head = cell_rec[0];

  // Ring: cell i takes from cell i+1, the last cell from the head (or the
  // rewritten record during the write-back rotation)
  for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
    voice_rec_t nbr;
    if (i == NUM_VOICES - 1) begin : g_tail
      assign nbr = tail_in;
    end else begin : g_mid
      assign nbr = cell_rec[i+1];
    end
    sva_voice_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .rec_i  (nbr),
      .rec_o  (cell_rec[i])
    );
  end

  sva_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (map_rd_en),
    .rd_addr_i (SAMPLE_AW'(req_i.sample_number)),
    .rd_o      (map_rd),
    .wr_en_i   (map_wr_en),
    .wr_set_i  (map_wr_set),
    .wr_addr_i (SAMPLE_AW'(sample_q)),
    .wr_voice_i(map_wr_voice)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_acc     = req_i.valid && req_i.ready;

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.voice         = out_voice_q;
  assign rsp_o.played_sample = out_sample_q;
  assign rsp_o.played_pitch  = out_pitch_q;

  always_comb begin
    sample_ok = ({1'b0, req_i.sample_number} < num_sounds_q) &&
                (32'(req_i.sample_number) < MAX_SOUNDS);

    // Voice at the head is cnt_q; voices past the flag word never end
    end_sh    = flags_q >> cnt_q;
    ended     = end_sh[0];
    free_cand = (head.sample == '0) || (ended && !head.loops);
    prio_cand = prio_q > head.prio;

    // Distance from the scan start in round-robin order
    if (cnt_q >= start_q) begin
      rel_wide = {1'b0, cnt_q} - {1'b0, start_q};
    end else begin
      rel_wide = {1'b0, cnt_q} + (VOICE_W + 1)'(NUM_VOICES) - {1'b0, start_q};
    end
    rel = rel_wide[VOICE_W-1:0];

    // Voice choice for a play: mapped voice, free voice, lower priority, steal
    chosen_ok = 1'b1;
    if (hit_q) begin
      chosen_v = map_rd.voice;
    end else if (free_found_q) begin
      chosen_v = free_v_q;
    end else if (prio_found_q) begin
      chosen_v = prio_v_q;
    end else begin
      chosen_v  = start_q;
      chosen_ok = prio_q > low_prio_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    num_sounds_d = num_sounds_q;
    low_prio_d   = low_prio_q;
    mode_d       = mode_q;
    sample_d     = sample_q;
    prio_d       = prio_q;
    loop_d       = loop_q;
    pitch_d      = pitch_q;
    flags_d      = flags_q;
    cnt_d        = cnt_q;
    start_d      = start_q;
    hit_d        = hit_q;
    free_found_d = free_found_q;
    free_rel_d   = free_rel_q;
    free_v_d     = free_v_q;
    prio_found_d = prio_found_q;
    prio_rel_d   = prio_rel_q;
    prio_v_d     = prio_v_q;
    target_d     = target_q;
    clear_d      = clear_q;
    res_status_d = res_status_q;
    res_voice_d  = res_voice_q;
    res_sample_d = res_sample_q;
    res_pitch_d  = res_pitch_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_voice_d  = out_voice_q;
    out_sample_d = out_sample_q;
    out_pitch_d  = out_pitch_q;

    shift        = 1'b0;
    tail_in      = head;
    map_rd_en    = 1'b0;
    map_wr_en    = 1'b0;
    map_wr_set   = 1'b0;
    map_wr_voice = chosen_v;

    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_NUM_SOUNDS: num_sounds_d = cfg_i.data;
        CFG_LOW_PRIO:   low_prio_d   = cfg_i.data[PRIO_W-1:0];
        default: ;
      endcase
    end

    // Free the output register once the word is taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          mode_d       = req_i.mode;
          sample_d     = req_i.sample_number;
          prio_d       = req_i.priority_req;
          loop_d       = req_i.looping;
          pitch_d      = req_i.pitch;
          flags_d      = req_i.voice_end_flags;
          res_status_d = ST_NOTHING;
          res_voice_d  = '0;
          res_sample_d = '0;
          res_pitch_d  = '0;
          cnt_d        = '0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          prio_found_d = 1'b0;
          state_d      = S_FINISH;
          if ((req_i.mode == MODE_PLAY || req_i.mode == MODE_STOP_SAMPLE) && !sample_ok) begin
            res_status_d = ST_BAD;
          end else if (req_i.mode == MODE_PLAY || req_i.mode == MODE_STOP_SAMPLE) begin
            map_rd_en = 1'b1;
            state_d   = S_SCAN;
          end else if (req_i.mode == MODE_STOP_VOICE) begin
            res_voice_d = req_i.voice_index;
            if (32'(req_i.voice_index) < NUM_VOICES) begin
              target_d     = VOICE_W'(req_i.voice_index);
              clear_d      = 1'b1;
              res_status_d = ST_STOPPED;
              state_d      = S_WRITE;
            end
          end
        end
      end

      S_SCAN: begin
        shift = 1'b1;
        if (map_rd.valid && map_rd.voice == cnt_q && head.sample == sample_q) begin
          hit_d = 1'b1;
        end
        if (free_cand && (!free_found_q || rel < free_rel_q)) begin
          free_found_d = 1'b1;
          free_rel_d   = rel;
          free_v_d     = cnt_q;
        end
        if (prio_cand && (!prio_found_q || rel < prio_rel_q)) begin
          prio_found_d = 1'b1;
          prio_rel_d   = rel;
          prio_v_d     = cnt_q;
        end
        if (cnt_q == LAST_VOICE) begin
          state_d = S_DECIDE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_DECIDE: begin
        cnt_d   = '0;
        state_d = S_FINISH;
        if (mode_q == MODE_PLAY) begin
          if (chosen_ok) begin
            map_wr_en    = 1'b1;
            map_wr_set   = 1'b1;
            target_d     = chosen_v;
            clear_d      = 1'b0;
            start_d      = (chosen_v == LAST_VOICE) ? '0 : chosen_v + 1'b1;
            res_status_d = ST_PLAYED;
            res_voice_d  = VIDX_W'(chosen_v);
            res_sample_d = sample_q;
            res_pitch_d  = pitch_q;
            state_d      = S_WRITE;
          end else begin
            res_status_d = ST_REJECTED;
          end
        end else if (hit_q) begin
          // Stop by sample: drop the mapping and key off its voice
          map_wr_en    = 1'b1;
          map_wr_set   = 1'b0;
          target_d     = map_rd.voice;
          clear_d      = 1'b1;
          res_status_d = ST_STOPPED;
          res_voice_d  = VIDX_W'(map_rd.voice);
          state_d      = S_WRITE;
        end
      end

      S_WRITE: begin
        shift = 1'b1;
        if (cnt_q == target_q) begin
          if (clear_q) begin
            tail_in = '0;
          end else begin
            tail_in.sample = sample_q;
            tail_in.prio   = prio_q;
            tail_in.loops  = loop_q;
          end
        end
        if (cnt_q == LAST_VOICE) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      S_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_voice_d  = res_voice_q;
          out_sample_d = res_sample_q;
          out_pitch_d  = res_pitch_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      num_sounds_q <= NUM_SOUNDS_RST;
      low_prio_q   <= LOW_PRIO_RST;
      start_q      <= SCAN_START_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      num_sounds_q <= num_sounds_d;
      low_prio_q   <= low_prio_d;
      start_q      <= start_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload and scan scratch: no reset needed
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    sample_q     <= sample_d;
    prio_q       <= prio_d;
    loop_q       <= loop_d;
    pitch_q      <= pitch_d;
    flags_q      <= flags_d;
    cnt_q        <= cnt_d;
    hit_q        <= hit_d;
    free_found_q <= free_found_d;
    free_rel_q   <= free_rel_d;
    free_v_q     <= free_v_d;
    prio_found_q <= prio_found_d;
    prio_rel_q   <= prio_rel_d;
    prio_v_q     <= prio_v_d;
    target_q     <= target_d;
    clear_q      <= clear_d;
    res_status_q <= res_status_d;
    res_voice_q  <= res_voice_d;
    res_sample_q <= res_sample_d;
    res_pitch_q  <= res_pitch_d;
    out_status_q <= out_status_d;
    out_voice_q  <= out_voice_d;
    out_sample_q <= out_sample_d;
    out_pitch_q  <= out_pitch_d;
  end

endmodule

>>> src/sva_chk.sv
module sva_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [sva_pkg::STATUS_W-1:0]   rsp_status_i,
  input logic [sva_pkg::VIDX_W-1:0]     rsp_voice_i,
  input logic [sva_pkg::SAMPLE_W-1:0]   rsp_sample_i,
  input logic [sva_pkg::PITCH_W-1:0]    rsp_pitch_i
);
  import sva_pkg::*;

  // A stalled result word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
    $stable(rsp_voice_i) && $stable(rsp_sample_i) && $stable(rsp_pitch_i))
    else $error("result word changed while stalled");

  // One request in flight: no accept in the cycle after an accept
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while another is in flight");

  // A played voice is a real voice
  a_played_voice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_PLAYED |-> 32'(rsp_voice_i) < NUM_VOICES)
    else $error("played on a voice that does not exist");

  // Sample and pitch are only reported for a play
  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_PLAYED |-> rsp_sample_i == '0 && rsp_pitch_i == '0)
    else $error("sample or pitch set on a result that is not a play");

endmodule

bind sound_voice_allocator_top sva_chk u_sva_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_status_i(rsp_o.status),
  .rsp_voice_i (rsp_o.voice),
  .rsp_sample_i(rsp_o.played_sample),
  .rsp_pitch_i (rsp_o.played_pitch)
);
